// ----- hdl/kcs_pkg.sv -----
// kcs_pkg: request and status codes plus keyframe record types for the
// keyframe curve sampler; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package kcs_pkg;

    localparam logic [1:0] REQ_CLEAR  = 2'd0;
    localparam logic [1:0] REQ_APPEND = 2'd1;
    localparam logic [1:0] REQ_SAMPLE = 2'd2;

    localparam logic [2:0] STAT_VALUE   = 3'd0;
    localparam logic [2:0] STAT_EMPTY   = 3'd1;
    localparam logic [2:0] STAT_STORED  = 3'd2;
    localparam logic [2:0] STAT_FULL    = 3'd3;
    localparam logic [2:0] STAT_CLEARED = 3'd4;

    typedef struct packed {
        logic signed [31:0] z;
        logic signed [31:0] y;
        logic signed [31:0] x;
    } vec_t;

    typedef struct packed {
        vec_t               v;
        logic signed [31:0] t;
    } key_t;

endpackage

`default_nettype wire

// ----- hdl/kcs_interp.sv -----
// kcs_interp: weight division (restoring, one quotient bit per cycle) and
// three component lerps through one shared multiplier; depends on kcs_pkg
`timescale 1ns / 1ps
`default_nettype none

module kcs_interp
    import kcs_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         start,
    input  wire  [31:0] num,
    input  wire  [31:0] den,
    input  vec_t        v0,
    input  vec_t        v1,
    output logic        done,
    output vec_t        res
);

    localparam int WW  = FRAC_BITS + 1;
    localparam int SCW = $clog2(WW + 1);
    localparam int PW  = 33 + WW + 1;

    typedef enum logic [1:0] {I_IDLE, I_DIV, I_MUL} istate_t;

    istate_t                 state_reg;
    logic [SCW-1:0]          step_reg;
    logic [32:0]             rem_reg;
    logic [31:0]             den_reg;
    logic                    den_zero_reg;
    logic [WW-1:0]           q_reg;
    vec_t                    v0_reg;
    logic signed [32:0]      dx_reg, dy_reg, dz_reg;
    logic [1:0]              mcnt_reg;
    logic signed [PW-1:0]    prod_reg;
    vec_t                    res_reg;
    logic                    done_reg;

    logic [33:0]             rem_sub;
    logic                    ge;
    logic [WW-1:0]           wq;
    logic signed [32:0]      mul_a;
    logic signed [PW-1:0]    prod_next;
    logic signed [PW-1:0]    prod_sh;
    logic [1:0]              sel_prev;
    logic signed [31:0]      v0_sel;
    logic signed [31:0]      sum;

    assign rem_sub   = {1'b0, rem_reg} - {2'b00, den_reg};
    assign ge        = ~rem_sub[33];
    assign wq        = den_zero_reg ? '0 : q_reg;
    assign prod_next = mul_a * $signed({1'b0, wq});
    assign prod_sh   = prod_reg >>> FRAC_BITS;
    assign sel_prev  = mcnt_reg - 2'd1;
    assign sum       = v0_sel + $signed(prod_sh[31:0]);

    always_comb begin
        case (mcnt_reg)
            2'd0:    mul_a = dx_reg;
            2'd1:    mul_a = dy_reg;
            default: mul_a = dz_reg;
        endcase
    end

    always_comb begin
        case (sel_prev)
            2'd0:    v0_sel = v0_reg.x;
            2'd1:    v0_sel = v0_reg.y;
            default: v0_sel = v0_reg.z;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= I_IDLE;
            done_reg  <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            unique case (state_reg)
                I_IDLE: begin
                    if (start) begin
                        rem_reg      <= {1'b0, num};
                        den_reg      <= den;
                        den_zero_reg <= (den == 32'd0);
                        step_reg     <= '0;
                        v0_reg       <= v0;
                        dx_reg       <= {v1.x[31], v1.x} - {v0.x[31], v0.x};
                        dy_reg       <= {v1.y[31], v1.y} - {v0.y[31], v0.y};
                        dz_reg       <= {v1.z[31], v1.z} - {v0.z[31], v0.z};
                        state_reg    <= I_DIV;
                    end
                end
                I_DIV: begin
                    q_reg   <= {q_reg[WW-2:0], ge};
                    rem_reg <= ge ? {rem_sub[31:0], 1'b0} : {rem_reg[31:0], 1'b0};
                    if (step_reg == SCW'(WW - 1)) begin
                        mcnt_reg  <= 2'd0;
                        state_reg <= I_MUL;
                    end else begin
                        step_reg <= step_reg + 1'b1;
                    end
                end
                I_MUL: begin
                    if (mcnt_reg != 2'd3) begin
                        prod_reg <= prod_next;
                    end
                    if (mcnt_reg != 2'd0) begin
                        case (sel_prev)
                            2'd0:    res_reg.x <= sum;
                            2'd1:    res_reg.y <= sum;
                            default: res_reg.z <= sum;
                        endcase
                    end
                    if (mcnt_reg == 2'd3) begin
                        done_reg  <= 1'b1;
                        state_reg <= I_IDLE;
                    end
                    mcnt_reg <= mcnt_reg + 2'd1;
                end
                default: state_reg <= I_IDLE;
            endcase
        end
    end

    assign done = done_reg;
    assign res  = res_reg;

endmodule

`default_nettype wire

// ----- hdl/keyframe_curve_sampler_core.sv -----
// keyframe_curve_sampler_core: keyframe table, segment scan sequencer and
// result register; depends on kcs_pkg and kcs_interp
//
// usage: one request beat on s_ (tuser = request kind) gives one result beat
// on m_ (tuser = status). clear and append are handled in S_IDLE: the result
// is in the output register on the next cycle and the next beat can be taken
// as soon as that result leaves or is taken in the same cycle.
// a sample with n stored keys reads the first and last key (S_FIRST_WAIT,
// S_FIRST_CHK, S_LAST_CHK), scans segments at one key per cycle over the
// single table read port, then runs the weight division at one quotient bit
// per cycle and three lerps on one shared multiplier, and passes the result
// through the result register and S_EMIT to the output register; the next
// request beat can be taken as soon as that result leaves or is taken in the
// same cycle. s_tready is low while a sample is in flight.
// reset empties the table (key count to zero); key contents are not cleared.
// when the receiver stalls the result holds in the output register and no
// new request is taken until it has been taken.
`timescale 1ns / 1ps
`default_nettype none

module keyframe_curve_sampler_core
    import kcs_pkg::*;
#(
    parameter int MAX_KEYS  = 64,
    parameter int FRAC_BITS = 16
) (
    input  wire          aclk,
    input  wire          aresetn,
    input  wire          s_tvalid,
    output logic         s_tready,
    input  wire  [127:0] s_tdata,   // sample_time, in_x, in_y, in_z
    input  wire  [1:0]   s_tuser,   // req_type
    output logic         m_tvalid,
    input  wire          m_tready,
    output logic [95:0]  m_tdata,   // out_x, out_y, out_z
    output logic [2:0]   m_tuser    // status
);

    localparam int AW = $clog2(MAX_KEYS);
    localparam int CW = $clog2(MAX_KEYS + 1);

    typedef enum logic [2:0] {
        S_IDLE, S_FIRST_WAIT, S_FIRST_CHK, S_LAST_CHK, S_SCAN, S_INTERP, S_EMIT
    } state_t;

    state_t             state_reg;
    logic [CW-1:0]      cnt_reg;
    logic [AW-1:0]      rd_addr_reg;
    logic [AW-1:0]      idx_reg;
    key_t               rd_q;
    key_t               prev_reg;
    vec_t               last_reg;
    logic signed [31:0] tm_reg;
    logic [2:0]         res_status_reg;
    vec_t               res_vec_reg;
    logic               m_tvalid_reg;
    logic [2:0]         m_status_reg;
    vec_t               m_vec_reg;

    key_t               mem [MAX_KEYS];

    key_t               in_key;
    logic               accept;
    logic               do_append;
    logic [AW-1:0]      last_addr;
    logic               hit;
    logic               istart;
    logic [32:0]        num_w;
    logic [32:0]        den_w;
    logic               idone;
    vec_t               ires;
    logic [CW-1:0]      cnt_m1;

    assign in_key    = s_tdata;
    assign s_tready  = (state_reg == S_IDLE) && (!m_tvalid_reg || m_tready);
    assign accept    = s_tvalid && s_tready;
    assign do_append = accept && (s_tuser == REQ_APPEND) && (cnt_reg != CW'(MAX_KEYS));
    assign cnt_m1    = cnt_reg - 1'b1;
    assign last_addr = cnt_m1[AW-1:0];
    assign hit       = (tm_reg >= prev_reg.t) && (tm_reg <= rd_q.t);
    assign istart    = (state_reg == S_SCAN) && hit;
    assign num_w     = {tm_reg[31], tm_reg} - {prev_reg.t[31], prev_reg.t};
    assign den_w     = {rd_q.t[31], rd_q.t} - {prev_reg.t[31], prev_reg.t};

    always_ff @(posedge aclk) begin
        if (do_append) begin
            mem[cnt_reg[AW-1:0]] <= in_key;
        end
        rd_q <= mem[rd_addr_reg];
    end

    kcs_interp #(
        .FRAC_BITS(FRAC_BITS)
    ) u_interp (
        .aclk   (aclk),
        .aresetn(aresetn),
        .start  (istart),
        .num    (num_w[31:0]),
        .den    (den_w[31:0]),
        .v0     (prev_reg.v),
        .v1     (rd_q.v),
        .done   (idone),
        .res    (ires)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            cnt_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        m_vec_reg <= '0;
                        case (s_tuser)
                            REQ_CLEAR: begin
                                cnt_reg      <= '0;
                                m_status_reg <= STAT_CLEARED;
                                m_tvalid_reg <= 1'b1;
                            end
                            REQ_APPEND: begin
                                if (cnt_reg == CW'(MAX_KEYS)) begin
                                    m_status_reg <= STAT_FULL;
                                end else begin
                                    cnt_reg      <= cnt_reg + 1'b1;
                                    m_status_reg <= STAT_STORED;
                                end
                                m_tvalid_reg <= 1'b1;
                            end
                            default: begin
                                if (cnt_reg == '0) begin
                                    m_status_reg <= STAT_EMPTY;
                                    m_tvalid_reg <= 1'b1;
                                end else begin
                                    tm_reg      <= in_key.t;
                                    rd_addr_reg <= '0;
                                    state_reg   <= S_FIRST_WAIT;
                                end
                            end
                        endcase
                    end
                end
                S_FIRST_WAIT: begin
                    rd_addr_reg <= last_addr;
                    state_reg   <= S_FIRST_CHK;
                end
                S_FIRST_CHK: begin
                    if (tm_reg <= rd_q.t) begin
                        res_status_reg <= STAT_VALUE;
                        res_vec_reg    <= rd_q.v;
                        state_reg      <= S_EMIT;
                    end else begin
                        prev_reg    <= rd_q;
                        rd_addr_reg <= AW'(1);
                        state_reg   <= S_LAST_CHK;
                    end
                end
                S_LAST_CHK: begin
                    if (tm_reg >= rd_q.t) begin
                        res_status_reg <= STAT_VALUE;
                        res_vec_reg    <= rd_q.v;
                        state_reg      <= S_EMIT;
                    end else begin
                        last_reg <= rd_q.v;
                        idx_reg  <= AW'(1);
                        if (rd_addr_reg != AW'(MAX_KEYS - 1)) begin
                            rd_addr_reg <= rd_addr_reg + 1'b1;
                        end
                        state_reg <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (hit) begin
                        state_reg <= S_INTERP;
                    end else if (idx_reg == last_addr) begin
                        res_status_reg <= STAT_VALUE;
                        res_vec_reg    <= last_reg;
                        state_reg      <= S_EMIT;
                    end else begin
                        prev_reg <= rd_q;
                        idx_reg  <= idx_reg + 1'b1;
                        if (rd_addr_reg != AW'(MAX_KEYS - 1)) begin
                            rd_addr_reg <= rd_addr_reg + 1'b1;
                        end
                    end
                end
                S_INTERP: begin
                    if (idone) begin
                        res_status_reg <= STAT_VALUE;
                        res_vec_reg    <= ires;
                        state_reg      <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        m_status_reg <= res_status_reg;
                        m_vec_reg    <= res_vec_reg;
                        state_reg    <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tdata  = m_vec_reg;

    // key count stays within the table
    assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CW'(MAX_KEYS))
        else $error("key count beyond table depth");

    // a scan never runs on an empty table and stays inside the stored keys
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SCAN) |-> (cnt_reg >= CW'(2)) && (idx_reg != '0)
            && ({1'b0, idx_reg} < cnt_reg))
        else $error("segment scan index out of range");

    // only a sampled value carries nonzero data
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && (m_status_reg != STAT_VALUE)) |-> (m_vec_reg == '0))
        else $error("non-value status with nonzero data");

    // a clear or append request beat puts a result out next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && ((s_tuser == REQ_CLEAR) || (s_tuser == REQ_APPEND)))
            |=> m_tvalid_reg && (state_reg == S_IDLE))
        else $error("clear or append result missing");

    // interpolation completes only while waiting for it
    assert property (@(posedge aclk) disable iff (!aresetn)
        idone |-> (state_reg == S_INTERP))
        else $error("interpolation done outside of wait");

endmodule

`default_nettype wire

// ----- sim/tb_keyframe_curve_sampler_core.sv -----
// tb_keyframe_curve_sampler_core: stream-driven check of the keyframe curve sampler
// against a scoreboard that predicts clear, append and curve sample results
// depends on kcs_pkg and keyframe_curve_sampler_core
`timescale 1ns / 1ps

module tb_keyframe_curve_sampler_core;
    import kcs_pkg::*;

    localparam int KEY_DEPTH   = 64;
    localparam int WEIGHT_BITS = 16;
    localparam int ITEM_TARGET = 1900;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_CYCLES = 120;

    localparam logic [1:0]  REQ_SPARE = 2'd3;
    localparam logic [31:0] Q_MAX     = 32'h7FFF_FFFF;
    localparam logic [31:0] Q_MIN     = 32'h8000_0000;

    typedef struct packed {
        logic [2:0] status;
        vec_t       v;
    } curve_result_t;

    class curve_scoreboard;
        key_t            keys[KEY_DEPTH];
        int              key_count;
        curve_result_t   expected_q[$];
        int              mismatches;

        function new();
            key_count  = 0;
            mismatches = 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function logic [31:0] blend(logic signed [31:0] a, logic signed [31:0] b, longint w);
            longint diff;
            diff = longint'(b) - longint'(a);
            return a + 32'((diff * w) >>> WEIGHT_BITS);
        endfunction

        function curve_result_t sample_curve(logic signed [31:0] tm);
            curve_result_t r;
            longint        num, den, w;
            int            i, last;
            r.status = STAT_VALUE;
            r.v      = '0;
            if (key_count == 0) begin
                r.status = STAT_EMPTY;
                return r;
            end
            last = key_count - 1;
            if (tm <= keys[0].t) begin
                r.v = keys[0].v;
                return r;
            end
            r.v = keys[last].v;
            if (tm >= keys[last].t)
                return r;
            for (i = 0; i < last; i++) begin
                if (tm >= keys[i].t && tm <= keys[i + 1].t) begin
                    num = longint'(tm) - longint'(keys[i].t);
                    den = longint'(keys[i + 1].t) - longint'(keys[i].t);
                    w   = (den == 0) ? 0 : (num <<< WEIGHT_BITS) / den;
                    r.v.x = blend(keys[i].v.x, keys[i + 1].v.x, w);
                    r.v.y = blend(keys[i].v.y, keys[i + 1].v.y, w);
                    r.v.z = blend(keys[i].v.z, keys[i + 1].v.z, w);
                    return r;
                end
            end
            return r;
        endfunction

        function void note_request(logic [1:0] kind, key_t key);
            curve_result_t r;
            r.v = '0;
            case (kind)
                REQ_CLEAR: begin
                    key_count = 0;
                    r.status  = STAT_CLEARED;
                end
                REQ_APPEND: begin
                    if (key_count >= KEY_DEPTH) begin
                        r.status = STAT_FULL;
                    end else begin
                        keys[key_count] = key;
                        key_count++;
                        r.status = STAT_STORED;
                    end
                end
                default: r = sample_curve(key.t);
            endcase
            expected_q.insert(expected_q.size(), r);
        endfunction

        task report_mismatch(string msg);
            $display("[%0t] MISMATCH: %s", $realtime, msg);
            mismatches++;
        endtask

        task check_result(logic [2:0] status, vec_t v);
            curve_result_t e;
            if (expected_q.size() == 0) begin
                report_mismatch($sformatf("result beat with nothing pending, status %0d",
                                          status));
                return;
            end
            e = expected_q.pop_front();
            if (status !== e.status)
                report_mismatch($sformatf("status %0d, want %0d", status, e.status));
            if (v.x !== e.v.x)
                report_mismatch($sformatf("out_x %h, want %h", v.x, e.v.x));
            if (v.y !== e.v.y)
                report_mismatch($sformatf("out_y %h, want %h", v.y, e.v.y));
            if (v.z !== e.v.z)
                report_mismatch($sformatf("out_z %h, want %h", v.z, e.v.z));
        endtask
    endclass

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [127:0] s_tdata = '0;
    logic [1:0]   s_tuser = REQ_CLEAR;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [95:0]  m_tdata;
    logic [2:0]   m_tuser;

    curve_scoreboard sb;
    int  sent = 0;
    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    bit  hold_request = 1'b0;
    bit  pressure_done = 1'b0;

    keyframe_curve_sampler_core #(
        .MAX_KEYS  (KEY_DEPTH),
        .FRAC_BITS (WEIGHT_BITS)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // result side: random stalls plus one long hold-off on request
    initial begin
        forever begin
            @(negedge aclk);
            if (hold_request) begin
                hold_request = 1'b0;
                repeat (HOLD_CYCLES) begin
                    m_tready <= 1'b0;
                    @(negedge aclk);
                end
            end
            m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tuser, vec_t'(m_tdata));
    end

    task send_beat(logic [1:0] kind, logic [31:0] t, logic [31:0] x, logic [31:0] y,
                   logic [31:0] z);
        key_t k;
        k.t   = t;
        k.v.x = x;
        k.v.y = y;
        k.v.z = z;
        @(negedge aclk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= k;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        sb.note_request(kind, k);
        sent++;
    endtask

    function logic [31:0] pick_value();
        case ($urandom_range(0, 3))
            0: return 32'($urandom_range(0, 200 * 65536)) - 32'(100 * 65536);
            1: begin
                case ($urandom_range(0, 3))
                    0: return Q_MAX;
                    1: return Q_MIN;
                    2: return 32'h0;
                    default: return 32'hFFFF_FFFF;
                endcase
            end
            default: return $urandom;
        endcase
    endfunction

    // well-formed run: optional clear, ascending keys with some ties and
    // reversals, then samples aimed mostly inside segments
    task automatic run_sequence(int n_keys, int n_samples, bit do_clear);
        logic signed [31:0] times[$];
        logic signed [31:0] t, tm;
        logic [31:0]        span;
        logic [1:0]         kind;
        int                 k, i, shift, roll;
        if (do_clear)
            send_beat(REQ_CLEAR, $urandom, $urandom, $urandom, $urandom);
        t = $urandom;
        t = t >>> $urandom_range(1, 8);
        for (k = 0; k < n_keys; k++) begin
            if (k > 0) begin
                shift = $urandom_range(0, 20);
                roll  = $urandom_range(0, 19);
                if (roll < 2)
                    t = t;
                else if (roll == 2)
                    t = t - 32'($urandom_range(1, 1 << shift));
                else
                    t = t + 32'($urandom_range(0, 1 << shift));
            end
            times.insert(times.size(), t);
            send_beat(REQ_APPEND, t, pick_value(), pick_value(), pick_value());
        end
        for (k = 0; k < n_samples; k++) begin
            roll = $urandom_range(0, 9);
            if (times.size() < 2 || roll == 0) begin
                tm = $urandom;
            end else if (roll == 1) begin
                tm = times[$urandom_range(0, times.size() - 1)];
            end else if (roll == 2) begin
                tm = ($urandom_range(0, 1) == 0) ? times[0] - 32'($urandom_range(0, 999))
                                                 : times[$] + 32'($urandom_range(0, 999));
            end else begin
                i = $urandom_range(0, times.size() - 2);
                if (times[i + 1] > times[i]) begin
                    span = 32'(longint'(times[i + 1]) - longint'(times[i]));
                    tm   = times[i] + 32'($urandom_range(0, span));
                end else begin
                    tm = times[i];
                end
            end
            kind = ($urandom_range(0, 9) == 0) ? REQ_SPARE : REQ_SAMPLE;
            send_beat(kind, tm, $urandom, $urandom, $urandom);
        end
    endtask

    initial begin
        int n;
        sb = new();
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: empty table, extremes, ties, out-of-order times, clear
        send_beat(REQ_SAMPLE, 32'h0, 32'h0, 32'h0, 32'h0);
        send_beat(REQ_SPARE, Q_MAX, Q_MAX, Q_MAX, Q_MAX);
        send_beat(REQ_CLEAR, 32'h0, 32'h0, 32'h0, 32'h0);
        send_beat(REQ_APPEND, Q_MIN, Q_MAX, Q_MIN, 32'h0);
        send_beat(REQ_SAMPLE, Q_MIN, 32'h0, 32'h0, 32'h0);
        send_beat(REQ_SAMPLE, Q_MAX, 32'h0, 32'h0, 32'h0);
        send_beat(REQ_APPEND, 32'h0, Q_MIN, Q_MAX, 32'hFFFF_FFFF);
        send_beat(REQ_APPEND, 32'h0, 32'h1, 32'h2, 32'h3);
        send_beat(REQ_APPEND, Q_MAX, 32'hFFFF_FFFF, Q_MAX, Q_MIN);
        send_beat(REQ_APPEND, 32'h0001_0000, 32'h1234_5678, 32'hEDCB_A988, 32'h0000_8000);
        send_beat(REQ_SAMPLE, Q_MIN, 32'h0, 32'h0, 32'h0);
        send_beat(REQ_SAMPLE, Q_MAX, 32'h0, 32'h0, 32'h0);
        send_beat(REQ_SAMPLE, 32'hC000_0000, 32'h0, 32'h0, 32'h0);
        send_beat(REQ_SAMPLE, 32'h0, 32'h0, 32'h0, 32'h0);
        send_beat(REQ_SAMPLE, 32'h0000_8000, 32'h0, 32'h0, 32'h0);
        send_beat(REQ_SPARE, 32'h0000_C000, 32'h0, 32'h0, 32'h0);
        send_beat(REQ_SAMPLE, 32'hFFFF_FFFF, Q_MAX, Q_MAX, Q_MAX);
        send_beat(REQ_CLEAR, Q_MAX, Q_MAX, Q_MAX, Q_MAX);
        send_beat(REQ_SAMPLE, 32'h0001_0000, 32'h0, 32'h0, 32'h0);
        send_beat(REQ_APPEND, 32'h0001_0000, 32'h0002_0000, 32'hFFFE_0000, 32'h0);
        send_beat(REQ_SAMPLE, 32'h0000_0001, 32'h0, 32'h0, 32'h0);

        // fill past capacity once, then random runs
        run_sequence(KEY_DEPTH + 4, 8, 1'b1);
        while (sent < ITEM_TARGET) begin
            case ((sent / 250) % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 78; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 78; end
                default: begin send_idle_pct = 26; recv_stall_pct = 26; end
            endcase
            if (!pressure_done && sent >= 900 && send_idle_pct == 0 && recv_stall_pct == 0) begin
                pressure_done = 1'b1;
                hold_request  = 1'b1;
            end
            if ($urandom_range(0, 7) == 0) begin
                repeat ($urandom_range(1, 4))
                    send_beat(2'($urandom_range(0, 3)), $urandom, $urandom, $urandom, $urandom);
            end else begin
                n = ($urandom_range(0, 11) == 0) ? $urandom_range(60, 70) : $urandom_range(0, 12);
                run_sequence(n, $urandom_range(1, 8), $urandom_range(0, 9) != 0);
            end
        end

        @(negedge aclk);
        s_tvalid <= 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        while (sb.pending() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule
